/* rtl/dsm_pkg.sv */
// ----------------------------------------------------------------------------
// dsm_pkg: shared types and codes for the DFA state minimizer
// Request operation codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam logic [1:0] OP_INFO  = 2'd0;
    localparam logic [1:0] OP_TRANS = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic REG_STATES  = 1'b0;
    localparam logic REG_SYMBOLS = 1'b1;

    localparam int PADDR_W = 3;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_S_NEXT,
        ST_REP_RD,
        ST_PAIR_RD,
        ST_PAIR_CMP,
        ST_SYM_TR,
        ST_SYM_CL,
        ST_SYM_CMP,
        ST_MATCH,
        ST_MISS,
        ST_NEW,
        ST_ADV,
        ST_O_START,
        ST_O_START_W,
        ST_O_RD,
        ST_O_LD,
        ST_O_WAIT
    } seq_state_t;

endpackage

/* rtl/dsm_if.sv */
// ----------------------------------------------------------------------------
// dsm_req_if / dsm_rsp_if: request and result channels
// Valid/ready channels carrying the load/run request and the per-state result.
// ----------------------------------------------------------------------------
interface dsm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [5:0] state_index;
    logic [6:0] symbol;
    logic [5:0] next_state;
    logic       has_next;
    logic       accepting;
    logic [7:0] token_id;

    modport source (output valid, operation, state_index, symbol, next_state,
                    has_next, accepting, token_id, input ready);
    modport sink   (input valid, operation, state_index, symbol, next_state,
                    has_next, accepting, token_id, output ready);
endinterface

interface dsm_rsp_if;
    logic       valid;
    logic       ready;
    logic [5:0] out_state;
    logic [5:0] class_id;
    logic [6:0] class_count;
    logic [5:0] start_class;
    logic       last;

    modport source (output valid, out_state, class_id, class_count, start_class,
                    last, input ready);
    modport sink   (input valid, out_state, class_id, class_count, start_class,
                    last, output ready);
endinterface

/* rtl/dfa_state_minimizer.sv */
// ----------------------------------------------------------------------------
// dfa_state_minimizer: Moore partition refinement of a loaded automaton
// Holds state info and a transition table, refines the state partition until
// stable on a run request, then reports each state's class in state order.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | operation, state_index, symbol, next_state, has_next,
//          |     | accepting, token_id
//  rsp     | out | out_state, class_id, class_count, start_class, last
//  apb     | in  | states_in_use (0x0), symbols_in_use (0x4)
//
//  Each load is written when it is accepted. A run round fetches each state,
//  then tries each representative in turn, reading and comparing the pair and
//  then each symbol, stepping on after a miss; it writes the class and advances.
//  The transition memory port is the pacing unit. Rounds repeat until the class
//  count stops changing. Output reads the start class, then each result in turn.
//  After reset a clearing pass over 2^(clog2(MAX_STATES)+clog2(ALPHABET_SIZE))
//  transition entries (8192 by default) zeroes the transition and state info
//  memories; req.ready stays low meanwhile. A stalled result holds until taken.
// ----------------------------------------------------------------------------
module dfa_state_minimizer #(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    dsm_req_if.sink                     req,
    dsm_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dsm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import dsm_pkg::*;

    localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CW = $clog2(MAX_STATES + 1);
    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int MW = $clog2(ALPHABET_SIZE + 1);
    localparam int TW = SW + AW;
    localparam int SD = 1 << SW;
    localparam int TD = 1 << TW;

    // ---------------- configuration registers ----------------
    logic [6:0] states_reg;
    logic [7:0] symbols_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_SYMBOLS) ? {24'd0, symbols_reg} : {25'd0, states_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            states_reg  <= 7'd64;
            symbols_reg <= 8'd127;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_STATES:  states_reg  <= pwdata[6:0];
                REG_SYMBOLS: symbols_reg <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    // effective counts, clamped into range
    logic [CW-1:0] n_eff;
    logic [MW-1:0] m_eff;
    always_comb
    begin
        if (states_reg == 7'd0)
            n_eff = CW'(1);
        else if (32'(states_reg) > MAX_STATES)
            n_eff = CW'(MAX_STATES);
        else
            n_eff = CW'(states_reg);
        if (32'(symbols_reg) > ALPHABET_SIZE)
            m_eff = MW'(ALPHABET_SIZE);
        else
            m_eff = MW'(symbols_reg);
    end

    // ---------------- sequencer registers ----------------
    seq_state_t    state_reg, state_next;
    logic [TW-1:0] clr_reg;
    logic [SW-1:0] s_reg;
    logic [SW-1:0] r_reg;
    logic [AW-1:0] a_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] prev_reg;
    logic [CW-1:0] n_reg;
    logic [MW-1:0] m_reg;
    logic          bank_reg;
    logic          init_reg;
    logic          vs_reg, vt_reg;
    logic [SW-1:0] start_reg;

    // memory read data
    logic [SW:0]   tr_rd0_reg, tr_rd1_reg;    // {valid, target}
    logic [SW-1:0] cls_rd0_reg, cls_rd1_reg;
    logic [SW-1:0] rep_rd_reg;
    logic [8:0]    info_rd0_reg, info_rd1_reg; // {accepting, token}

    logic [SW:0]   tr_mem   [TD];
    logic [SW-1:0] cls_mem  [2*SD];           // two banks: current and next
    logic [SW-1:0] rep_mem  [SD];
    logic [8:0]    info_mem [SD];

    logic req_acc;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid & req.ready;

    logic info_ok, trans_ok;
    assign info_ok  = (32'(req.state_index) < MAX_STATES);
    assign trans_ok = info_ok && (32'(req.symbol) < ALPHABET_SIZE);

    // ---------------- memory ports ----------------
    logic          tr_we;
    logic [TW-1:0] tr_wa;
    logic [SW:0]   tr_wd;
    logic          info_we;
    logic [SW-1:0] info_wa;
    logic [8:0]    info_wd;
    logic          cls_we;
    logic [SW:0]   cls_wa;
    logic [SW-1:0] cls_wd;
    logic [SW:0]   cls_ra0, cls_ra1;
    logic          same_start, sym_diff, done_round;
    logic [CW-1:0] s_inc, r_inc;
    logic [MW-1:0] a_inc;

    assign s_inc = CW'(s_reg) + CW'(1);
    assign r_inc = CW'(r_reg) + CW'(1);
    assign a_inc = MW'(a_reg) + MW'(1);
    assign done_round = !init_reg && (count_reg == prev_reg);

    assign same_start = (info_rd0_reg[8] == info_rd1_reg[8])
                        && (!info_rd0_reg[8] || info_rd0_reg[7:0] == info_rd1_reg[7:0]);
    assign sym_diff = (vs_reg != vt_reg) || (vs_reg && cls_rd0_reg != cls_rd1_reg);

    always_comb
    begin
        tr_we   = 1'b0;
        tr_wa   = clr_reg;
        tr_wd   = '0;
        info_we = 1'b0;
        info_wa = clr_reg[SW-1:0];
        info_wd = '0;
        cls_we  = 1'b0;
        cls_wa  = {~bank_reg, s_reg};
        cls_wd  = r_reg;
        cls_ra0 = {bank_reg, s_reg};
        cls_ra1 = {bank_reg, rep_rd_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                tr_we   = 1'b1;
                info_we = 1'b1;
            end
            ST_IDLE:
            begin
                tr_wa   = {SW'(req.state_index), AW'(req.symbol)};
                tr_wd   = {req.has_next && (32'(req.next_state) < MAX_STATES),
                           SW'(req.next_state)};
                info_wa = SW'(req.state_index);
                info_wd = {req.accepting, req.token_id};
                tr_we   = req_acc && (req.operation == OP_TRANS) && trans_ok;
                info_we = req_acc && (req.operation == OP_INFO) && info_ok;
            end
            ST_SYM_CL:
            begin
                cls_ra0 = {bank_reg, tr_rd0_reg[SW-1:0]};
                cls_ra1 = {bank_reg, tr_rd1_reg[SW-1:0]};
            end
            ST_MATCH: cls_we = 1'b1;
            ST_NEW:
            begin
                cls_we = 1'b1;
                cls_wd = SW'(count_reg);
            end
            ST_O_START: cls_ra0 = {bank_reg, SW'(0)};
            default:    ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tr_we)
            tr_mem[tr_wa] <= tr_wd;
        tr_rd0_reg <= tr_mem[{s_reg, a_reg}];
        tr_rd1_reg <= tr_mem[{rep_rd_reg, a_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (info_we)
            info_mem[info_wa] <= info_wd;
        info_rd0_reg <= info_mem[s_reg];
        info_rd1_reg <= info_mem[rep_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cls_we)
            cls_mem[cls_wa] <= cls_wd;
        cls_rd0_reg <= cls_mem[cls_ra0];
        cls_rd1_reg <= cls_mem[cls_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_NEW)
            rep_mem[SW'(count_reg)] <= s_reg;
        if (state_reg == ST_REP_RD)
            rep_rd_reg <= rep_mem[r_reg];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (&clr_reg) state_next = ST_IDLE;
            ST_IDLE:      if (req_acc && req.operation == OP_RUN) state_next = ST_S_NEXT;
            ST_S_NEXT:    state_next = (count_reg == '0) ? ST_NEW : ST_REP_RD;
            ST_REP_RD:    state_next = ST_PAIR_RD;
            ST_PAIR_RD:   state_next = ST_PAIR_CMP;
            ST_PAIR_CMP:
            begin
                if (init_reg)
                    state_next = same_start ? ST_MATCH : ST_MISS;
                else if (cls_rd0_reg != cls_rd1_reg)
                    state_next = ST_MISS;
                else
                    state_next = (m_reg == '0) ? ST_MATCH : ST_SYM_TR;
            end
            ST_SYM_TR:    state_next = ST_SYM_CL;
            ST_SYM_CL:    state_next = ST_SYM_CMP;
            ST_SYM_CMP:
            begin
                if (sym_diff)
                    state_next = ST_MISS;
                else
                    state_next = (a_inc == m_reg) ? ST_MATCH : ST_SYM_TR;
            end
            ST_MATCH:     state_next = ST_ADV;
            ST_MISS:      state_next = (r_inc < count_reg) ? ST_REP_RD : ST_NEW;
            ST_NEW:       state_next = ST_ADV;
            ST_ADV:
            begin
                if (s_inc < n_reg)
                    state_next = ST_S_NEXT;
                else
                    state_next = done_round ? ST_O_START : ST_S_NEXT;
            end
            ST_O_START:   state_next = ST_O_START_W;
            ST_O_START_W: state_next = ST_O_RD;
            ST_O_RD:      state_next = ST_O_LD;
            ST_O_LD:      state_next = ST_O_WAIT;
            ST_O_WAIT:
            begin
                if (rsp.ready)
                    state_next = rsp.last ? ST_IDLE : ST_O_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            s_reg     <= '0;
            r_reg     <= '0;
            a_reg     <= '0;
            count_reg <= '0;
            prev_reg  <= '0;
            n_reg     <= CW'(1);
            m_reg     <= '0;
            bank_reg  <= 1'b0;
            init_reg  <= 1'b0;
            vs_reg    <= 1'b0;
            vt_reg    <= 1'b0;
            rsp.valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + TW'(1);
                ST_IDLE:
                begin
                    if (req_acc && req.operation == OP_RUN)
                    begin
                        n_reg     <= n_eff;
                        m_reg     <= m_eff;
                        init_reg  <= 1'b1;
                        s_reg     <= '0;
                        count_reg <= '0;
                    end
                end
                ST_S_NEXT:   r_reg <= '0;
                ST_PAIR_CMP: a_reg <= '0;
                ST_SYM_CL:
                begin
                    // a target outside the states in use counts as none
                    vs_reg <= tr_rd0_reg[SW] && (CW'(tr_rd0_reg[SW-1:0]) < n_reg);
                    vt_reg <= tr_rd1_reg[SW] && (CW'(tr_rd1_reg[SW-1:0]) < n_reg);
                end
                ST_SYM_CMP:  a_reg <= a_reg + AW'(1);
                ST_MISS:     r_reg <= r_reg + SW'(1);
                ST_NEW:      count_reg <= count_reg + CW'(1);
                ST_ADV:
                begin
                    if (s_inc < n_reg)
                        s_reg <= s_reg + SW'(1);
                    else
                    begin
                        // round done: next bank becomes current
                        bank_reg <= ~bank_reg;
                        s_reg    <= '0;
                        prev_reg <= count_reg;
                        init_reg <= 1'b0;
                        if (!done_round)
                            count_reg <= '0;
                    end
                end
                ST_O_LD:     rsp.valid <= 1'b1;
                ST_O_WAIT:
                begin
                    if (rsp.ready)
                    begin
                        rsp.valid <= 1'b0;
                        s_reg     <= s_reg + SW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_O_START_W)
            start_reg <= cls_rd0_reg;
        if (state_reg == ST_O_LD)
        begin
            rsp.out_state   <= 6'(s_reg);
            rsp.class_id    <= 6'(cls_rd0_reg);
            rsp.class_count <= 7'(count_reg);
            rsp.start_class <= 6'(start_reg);
            rsp.last        <= (s_inc == n_reg);
        end
    end

    // ---------------- assertions ----------------
    a_rsp_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> state_reg == ST_O_WAIT)
        else $error("result valid outside output wait");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && rsp.last) |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after last result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADV) |-> count_reg <= n_reg)
        else $error("class count above state count");

endmodule

/* dv/dfa_state_minimizer_tb.sv */
// ----------------------------------------------------------------------------
// dfa_state_minimizer_tb: self-checking bench for the DFA state minimizer
// Loads automata through the request channel, configures state and symbol
// counts over APB, runs minimization and checks every per-state class result
// against an in-bench partition refinement predictor.
// ----------------------------------------------------------------------------
module dfa_state_minimizer_tb;
    import dsm_pkg::*;

    // opcode with no effect, used as noise
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0] op;
        logic [5:0] st;
        logic [6:0] sym;
        logic [5:0] nx;
        logic       hn;
        logic       acc;
        logic [7:0] tok;
    } dfa_req_t;

    typedef struct {
        logic [5:0] out_state;
        logic [5:0] class_id;
        logic [6:0] class_count;
        logic [5:0] start_class;
        logic       last;
    } class_rsp_t;

    // directed row: either a register write or a request; typed != 0 gives the
    // class count of a run whose result is "every state in class 0"
    typedef struct {
        bit        is_cfg;
        logic      rg;
        int        val;
        dfa_req_t  it;
        int        typed;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dsm_req_if req_if ();
    dsm_rsp_if rsp_if ();

    dfa_state_minimizer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor copy of the automaton and partition
    // ------------------------------------------------------------------
    logic [5:0] edge_to  [64][128];
    bit         edge_ok  [64][128];
    bit         acc_flag [64];
    logic [7:0] tok_id   [64];
    int         cls      [64];
    int         cfg_states;
    int         cfg_symbols;

    class_rsp_t pending_classes[$];
    int         errors;
    int         cycles;
    bit         idle_on;
    bit         hold_req;

    // class reached from s on symbol a, -1 when no live transition
    function automatic int reach(int s, int a, int n);
        if (!edge_ok[s][a] || edge_to[s][a] >= n)
            return -1;
        return cls[edge_to[s][a]];
    endfunction

    function automatic bit same_moves(int s, int t, int n, int m);
        if (cls[s] != cls[t])
            return 0;
        for (int a = 0; a < m; a++)
            if (reach(s, a, n) != reach(t, a, n))
                return 0;
        return 1;
    endfunction

    function automatic bit same_seed(int s, int t);
        if (acc_flag[s] != acc_flag[t])
            return 0;
        return !acc_flag[s] || tok_id[s] == tok_id[t];
    endfunction

    // dense renumbering, classes ordered by lowest member
    function automatic int regroup(int n, int m, bit seed);
        int rep[64];
        int nc[64];
        int cnt;
        bit hit;
        cnt = 0;
        for (int s = 0; s < n; s++)
        begin
            hit = 0;
            for (int r = 0; r < cnt && !hit; r++)
            begin
                if (seed ? same_seed(s, rep[r]) : same_moves(s, rep[r], n, m))
                begin
                    nc[s] = r;
                    hit = 1;
                end
            end
            if (!hit)
            begin
                rep[cnt] = s;
                nc[s] = cnt;
                cnt++;
            end
        end
        for (int s = 0; s < n; s++)
            cls[s] = nc[s];
        return cnt;
    endfunction

    function automatic void predict_request(dfa_req_t it, int typed);
        int n;
        int m;
        int cnt;
        int prev;
        class_rsp_t r;
        case (it.op)
            OP_INFO:
            begin
                acc_flag[it.st] = it.acc;
                tok_id[it.st] = it.tok;
            end
            OP_TRANS:
            begin
                edge_to[it.st][it.sym] = it.nx;
                edge_ok[it.st][it.sym] = it.hn;
            end
            OP_RUN:
            begin
                n = (cfg_states < 1) ? 1 : (cfg_states > 64) ? 64 : cfg_states;
                m = (cfg_symbols > 128) ? 128 : cfg_symbols;
                cnt = regroup(n, m, 1);
                do
                begin
                    prev = cnt;
                    cnt = regroup(n, m, 0);
                end
                while (cnt != prev);
                for (int s = 0; s < n; s++)
                begin
                    r.out_state = 6'(s);
                    r.class_id = 6'((typed != 0) ? 0 : cls[s]);
                    r.class_count = 7'((typed != 0) ? typed : cnt);
                    r.start_class = 6'((typed != 0) ? 0 : cls[0]);
                    r.last = (s + 1 == n);
                    pending_classes = {pending_classes, r};
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        rsp_if.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // hold off from the first offered result onward
                rsp_if.ready = 0;
                while (!rsp_if.valid)
                    @(negedge clk);
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_if.ready = 0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            rsp_if.ready = 1;
        end
    end

    task automatic report(string what, int got, int want);
        $display("ERROR %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        class_rsp_t w;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_classes.size() == 0)
                report("unexpected result, out_state", rsp_if.out_state, -1);
            else
            begin
                w = pending_classes.pop_front();
                if (rsp_if.out_state !== w.out_state)
                    report("out_state", rsp_if.out_state, w.out_state);
                if (rsp_if.class_id !== w.class_id)
                    report("class_id", rsp_if.class_id, w.class_id);
                if (rsp_if.class_count !== w.class_count)
                    report("class_count", rsp_if.class_count, w.class_count);
                if (rsp_if.start_class !== w.start_class)
                    report("start_class", rsp_if.start_class, w.start_class);
                if (rsp_if.last !== w.last)
                    report("last", rsp_if.last, w.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(dfa_req_t it, int typed);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            req_if.valid = 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        @(negedge clk);
        req_if.valid = 1;
        req_if.operation = it.op;
        req_if.state_index = it.st;
        req_if.symbol = it.sym;
        req_if.next_state = it.nx;
        req_if.has_next = it.hn;
        req_if.accepting = it.acc;
        req_if.token_id = it.tok;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predict_request(it, typed);
    endtask

    // drop valid, let every expected result arrive, then let a load settle
    task automatic wait_idle();
        @(negedge clk);
        req_if.valid = 0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic rg, int val);
        wait_idle();
        @(negedge clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = {rg, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (rg == REG_STATES)
            cfg_states = val & 'h7F;
        else
            cfg_symbols = val & 'hFF;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    function automatic dfa_req_t rand_load(int n, int m);
        dfa_req_t it;
        int pick;
        pick = $urandom_range(0, 19);
        it.op = (pick < 6) ? OP_INFO : (pick < 19) ? OP_TRANS : OP_NONE;
        // mostly inside the states/symbols in use, sometimes anywhere
        it.st = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, n - 1));
        it.sym = 7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, (m < 1) ? 0 : m - 1));
        it.nx = 6'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                               : $urandom_range(0, n - 1));
        it.hn = ($urandom_range(0, 4) != 0);
        it.acc = 1'($urandom_range(0, 1));
        it.tok = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 2));
        return it;
    endfunction

    dir_row_t dir_rows[26];

    initial
    begin
        dfa_req_t it;
        dfa_req_t run_it;
        int n;
        int m;
        dir_rows = '{
            // defaults, empty automaton: a single class
            '{0, 0, 0, '{OP_RUN, 0, 0, 0, 0, 0, 0}, 1},
            '{1, REG_STATES, 4, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{1, REG_SYMBOLS, 2, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            // non-accepting token is ignored
            '{0, 0, 0, '{OP_INFO, 0, 0, 0, 0, 0, 255}, 0},
            '{0, 0, 0, '{OP_INFO, 1, 0, 0, 0, 1, 0}, 0},
            '{0, 0, 0, '{OP_INFO, 2, 0, 0, 0, 1, 0}, 0},
            '{0, 0, 0, '{OP_INFO, 3, 0, 0, 0, 1, 255}, 0},
            '{0, 0, 0, '{OP_TRANS, 0, 0, 1, 1, 0, 0}, 0},
            // target beyond the states in use acts as no transition
            '{0, 0, 0, '{OP_TRANS, 0, 1, 63, 1, 0, 0}, 0},
            '{0, 0, 0, '{OP_TRANS, 1, 0, 2, 1, 0, 0}, 0},
            '{0, 0, 0, '{OP_TRANS, 2, 1, 2, 0, 0, 0}, 0},
            '{0, 0, 0, '{OP_NONE, 63, 127, 63, 1, 1, 255}, 0},
            '{0, 0, 0, '{OP_TRANS, 63, 127, 63, 1, 1, 255}, 0},
            '{0, 0, 0, '{OP_INFO, 63, 127, 63, 1, 1, 255}, 0},
            '{0, 0, 0, '{OP_RUN, 0, 0, 0, 0, 0, 0}, 0},
            // zero states acts as one
            '{1, REG_STATES, 0, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{0, 0, 0, '{OP_RUN, 0, 0, 0, 0, 0, 0}, 1},
            // state count clamps at 64, no symbols examined
            '{1, REG_STATES, 127, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{1, REG_SYMBOLS, 0, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{0, 0, 0, '{OP_RUN, 0, 0, 0, 0, 0, 0}, 0},
            // symbol count clamps at 128
            '{1, REG_STATES, 2, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{1, REG_SYMBOLS, 255, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{0, 0, 0, '{OP_RUN, 0, 0, 0, 0, 0, 0}, 0},
            '{1, REG_STATES, 64, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{1, REG_SYMBOLS, 1, '{OP_NONE, 0, 0, 0, 0, 0, 0}, 0},
            '{0, 0, 0, '{OP_RUN, 0, 0, 0, 0, 0, 0}, 0}
        };

        // predictor reset image
        for (int s = 0; s < 64; s++)
        begin
            acc_flag[s] = 0;
            tok_id[s] = 0;
            cls[s] = 0;
            for (int a = 0; a < 128; a++)
            begin
                edge_to[s][a] = 0;
                edge_ok[s][a] = 0;
            end
        end
        cfg_states = 64;
        cfg_symbols = 127;
        errors = 0;
        cycles = 0;
        idle_on = 1;
        hold_req = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 0;
        req_if.operation = OP_INFO;
        req_if.state_index = '0;
        req_if.symbol = '0;
        req_if.next_state = '0;
        req_if.has_next = 0;
        req_if.accepting = 0;
        req_if.token_id = '0;
        run_it = '{OP_RUN, 0, 0, 0, 0, 0, 0};

        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed part; ready stays low through the clearing pass
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                cfg_write(dir_rows[i].rg, dir_rows[i].val);
            else
                send_request(dir_rows[i].it, dir_rows[i].typed);
        end

        // random phases: config, loads, run; small sizes keep runs short
        for (int ph = 0; ph < 8; ph++)
        begin
            n = (ph == 5) ? 64 : $urandom_range(2, 10);
            m = (ph == 5) ? 2 : $urandom_range(1, 6);
            if (ph >= 6)
                idle_on = 0;    // quiet tail
            cfg_write(REG_STATES, n);
            cfg_write(REG_SYMBOLS, m);
            repeat ((ph == 5) ? 6 : 10)
            begin
                it = rand_load(n, m);
                send_request(it, 0);
            end
            if (ph == 2)
            begin
                // long result stall while loads keep coming: block backs up
                hold_req = 1;
                send_request(run_it, 0);
                repeat (5)
                begin
                    it = rand_load(n, m);
                    send_request(it, 0);
                end
            end
            send_request(run_it, 0);
        end

        wait_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
